FILE: hdl/mfld_pkg.sv
`default_nettype none
package mfld_pkg;

  localparam int FRAME_WIDTH_DEF = 102;
  localparam int PAGE_COUNT_DEF  = 8;
  localparam int COORD_W         = 7;
  localparam int ADDR_IN_W       = 10;
  localparam int DATA_W          = 8;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PT_RD,
    ST_PT_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } step_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } point_t;

endpackage
`default_nettype wire

FILE: hdl/mfld_line_step.sv
`default_nettype none
module mfld_line_step (
  input  wire                             clk,
  input  wire mfld_pkg::step_ctl_t        ctl,
  input  wire [mfld_pkg::COORD_W-1:0]     x_start,
  input  wire [mfld_pkg::COORD_W-1:0]     y_start,
  input  wire [mfld_pkg::COORD_W-1:0]     x_end,
  input  wire [mfld_pkg::COORD_W-1:0]     y_end,
  output mfld_pkg::point_t                pt
);
  import mfld_pkg::*;

  logic [COORD_W-1:0] x_cur_r, y_cur_r, x_end_r, y_end_r;
  logic [COORD_W-1:0] major_r, minor_r, acc_r, remain_r;
  logic               x_major_r, x_dir_r, y_dir_r;

  logic [COORD_W-1:0] dx, dy;
  logic [COORD_W:0]   acc_sum;
  logic               wrap;
  logic [COORD_W-1:0] acc_nxt, x_nxt, y_nxt;

  // shared add/compare: remainder of minor*k/major, advanced one step at a time
  always_comb begin
    dx      = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
    dy      = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
    acc_sum = {1'b0, acc_r} + {1'b0, minor_r};
    wrap    = acc_sum >= {1'b0, major_r};
    acc_nxt = wrap ? COORD_W'(acc_sum - {1'b0, major_r}) : COORD_W'(acc_sum);
    x_nxt   = x_cur_r;
    y_nxt   = y_cur_r;
    if (x_major_r || wrap) begin
      x_nxt = x_dir_r ? x_cur_r + 1'b1 : x_cur_r - 1'b1;
    end
    if (!x_major_r || wrap) begin
      y_nxt = y_dir_r ? y_cur_r + 1'b1 : y_cur_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_cur_r   <= x_start;
      y_cur_r   <= y_start;
      x_end_r   <= x_end;
      y_end_r   <= y_end;
      x_dir_r   <= x_end >= x_start;
      y_dir_r   <= y_end >= y_start;
      x_major_r <= dx >= dy;
      major_r   <= (dx >= dy) ? dx : dy;
      minor_r   <= (dx >= dy) ? dy : dx;
      remain_r  <= (dx >= dy) ? dx : dy;
      acc_r     <= '0;
    end else if (ctl.step) begin
      x_cur_r  <= x_nxt;
      y_cur_r  <= y_nxt;
      acc_r    <= acc_nxt;
      remain_r <= remain_r - 1'b1;
    end
  end

  assign pt.last = remain_r == '0;
  assign pt.x    = pt.last ? x_end_r : x_cur_r;
  assign pt.y    = pt.last ? y_end_r : y_cur_r;

endmodule
`default_nettype wire

FILE: hdl/mfld_frame_mem.sv
`default_nettype none
module mfld_frame_mem #(
  parameter int DEPTH = mfld_pkg::FRAME_WIDTH_DEF * mfld_pkg::PAGE_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire [AW-1:0]                 waddr,
  input  wire [mfld_pkg::DATA_W-1:0]   wdata,
  input  wire                          re,
  input  wire [AW-1:0]                 raddr,
  output logic [mfld_pkg::DATA_W-1:0]  rdata
);
  import mfld_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hdl/mono_framebuffer_line_drawer_unit.sv
// Monochrome paged framebuffer (PAGE_COUNT pages of FRAME_WIDTH bytes, bit y%8 of byte
// (y/8)*FRAME_WIDTH+x) with pixel, line, clear-all and byte-read requests, one result per
// request. One request is handled at a time; in_stall is low only when the sequencer is idle.
// A pixel is one plotted point, a line major+1 points where major is the larger of |dx| and
// |dy| (off-frame points are stepped past without a memory access), a clear writes every
// byte and a read fetches one byte; each request also waits in ST_DONE for as long as the
// previous result is held by out_stall. Each plotted point is a read-modify-write of the
// frame memory, the line is stepped by the one shared remainder adder/compare, and the
// clear sweep writes one byte per cycle. After reset the block runs the same clearing pass
// over all PAGE_COUNT*FRAME_WIDTH bytes (816 by default) before it takes its first transfer.
`default_nettype none
module mono_framebuffer_line_drawer_unit #(
  parameter int FRAME_WIDTH = mfld_pkg::FRAME_WIDTH_DEF,
  parameter int PAGE_COUNT  = mfld_pkg::PAGE_COUNT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       in_req_type,
  input  wire  [mfld_pkg::COORD_W-1:0]     in_x_start,
  input  wire  [mfld_pkg::COORD_W-1:0]     in_y_start,
  input  wire  [mfld_pkg::COORD_W-1:0]     in_x_end,
  input  wire  [mfld_pkg::COORD_W-1:0]     in_y_end,
  input  wire                              in_set_pixels,
  input  wire  [mfld_pkg::ADDR_IN_W-1:0]   in_read_addr,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [mfld_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_was_read
);
  import mfld_pkg::*;

  localparam int DEPTH        = FRAME_WIDTH * PAGE_COUNT;
  localparam int FRAME_HEIGHT = PAGE_COUNT * 8;
  localparam int AW           = $clog2(DEPTH);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              clr_res_r, clr_res_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic              set_r, set_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic              res_read_r, res_read_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_read_r, out_read_nxt;

  step_ctl_t          step_ctl;
  point_t             pt;
  logic [COORD_W-1:0] ld_x_end, ld_y_end;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              in_frame, out_free, in_range;
  logic [AW-1:0]     pt_addr;
  logic [DATA_W-1:0] bit_mask;

  assign in_frame = (32'(pt.x) < 32'(FRAME_WIDTH)) && (32'(pt.y) < 32'(FRAME_HEIGHT));
  assign pt_addr  = AW'(32'(pt.y[COORD_W-1:3]) * FRAME_WIDTH + 32'(pt.x));
  assign in_range = 32'(in_read_addr) < 32'(DEPTH);
  assign out_free = !out_valid_r || !out_stall;
  assign bit_mask = DATA_W'(1) << bit_r;
  assign ld_x_end = (in_req_type == REQ_LINE) ? in_x_end : in_x_start;
  assign ld_y_end = (in_req_type == REQ_LINE) ? in_y_end : in_y_start;

  mfld_line_step u_step (
    .clk     (clk),
    .ctl     (step_ctl),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (ld_x_end),
    .y_end   (ld_y_end),
    .pt      (pt)
  );

  mfld_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = clr_res_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_PIXEL: state_nxt = ST_PT_RD;
            REQ_LINE:  state_nxt = ST_PT_RD;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_RD_WAIT;
          endcase
        end
      end
      ST_PT_RD: begin
        if (in_frame) begin
          state_nxt = ST_PT_WR;
        end else if (pt.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PT_WR:   state_nxt = pt.last ? ST_DONE : ST_PT_RD;
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    step_ctl      = '0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = set_r ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    mem_re        = 1'b0;
    mem_raddr     = pt_addr;
    clr_cnt_nxt   = clr_cnt_r;
    clr_res_nxt   = clr_res_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    set_nxt       = set_r;
    rd_ok_nxt     = rd_ok_r;
    res_data_nxt  = res_data_r;
    res_read_nxt  = res_read_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_read_nxt  = out_read_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        in_stall      = 1'b0;
        step_ctl.load = in_valid;
        set_nxt       = in_set_pixels;
        res_data_nxt  = '0;
        res_read_nxt  = in_req_type == REQ_READ;
        rd_ok_nxt     = in_range;
        clr_cnt_nxt   = '0;
        clr_res_nxt   = 1'b1;
        mem_re        = in_valid && in_range;
        mem_raddr     = AW'(in_read_addr);
      end
      ST_PT_RD: begin
        mem_re        = in_frame;
        addr_nxt      = pt_addr;
        bit_nxt       = pt.y[2:0];
        step_ctl.step = !in_frame && !pt.last;
      end
      ST_PT_WR: begin
        mem_we        = 1'b1;
        step_ctl.step = !pt.last;
      end
      ST_RD_WAIT: begin
        res_data_nxt = rd_ok_r ? mem_rdata : '0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_read_nxt  = res_read_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    bit_r      <= bit_nxt;
    set_r      <= set_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_data_r <= res_data_nxt;
    res_read_r <= res_read_nxt;
    out_data_r <= out_data_nxt;
    out_read_r <= out_read_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_was_read  = out_read_r;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mfld_pkg::*;

  localparam int FB_W      = FRAME_WIDTH_DEF;
  localparam int FB_PAGES  = PAGE_COUNT_DEF;
  localparam int FB_H      = FB_PAGES * 8;
  localparam int FB_BYTES  = FB_W * FB_PAGES;
  localparam int RAND_REQS = 600;

  typedef struct {
    logic [1:0]         kind;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic               on;
    logic [ADDR_IN_W-1:0] addr;
  } draw_req_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic              rd;
  } fb_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_PIXEL;
  logic [COORD_W-1:0]   in_x_start = '0;
  logic [COORD_W-1:0]   in_y_start = '0;
  logic [COORD_W-1:0]   in_x_end = '0;
  logic [COORD_W-1:0]   in_y_end = '0;
  logic                 in_set_pixels = 1'b0;
  logic [ADDR_IN_W-1:0] in_read_addr = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_read_data;
  logic                 out_was_read;

  draw_req_t  pending_reqs[$];
  fb_result_t due_results[$];
  draw_req_t  on_bus;
  fb_result_t want;
  logic [7:0] shadow_fb [0:FB_BYTES-1];
  int         total_reqs;
  int         sent_cnt = 0;
  int         seen_cnt = 0;
  int         err_cnt = 0;
  int         kind_cnt [4] = '{0, 0, 0, 0};

  mono_framebuffer_line_drawer_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_x_start(in_x_start),
    .in_y_start(in_y_start),
    .in_x_end(in_x_end),
    .in_y_end(in_y_end),
    .in_set_pixels(in_set_pixels),
    .in_read_addr(in_read_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_was_read(out_was_read)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void fb_plot(int x, int y, logic on);
    int a;
    if (x >= FB_W || y >= FB_H) return;
    a = (y / 8) * FB_W + x;
    shadow_fb[a][y % 8] = on;
  endfunction

  function automatic int step_to(int from, int to, int off);
    return (to >= from) ? from + off : from - off;
  endfunction

  function automatic void fb_line(int x1, int y1, int x2, int y2, logic on);
    int mdx, mdy;
    mdx = (x2 >= x1) ? x2 - x1 : x1 - x2;
    mdy = (y2 >= y1) ? y2 - y1 : y1 - y2;
    if (mdx >= mdy) begin
      for (int k = 0; k < mdx; k++)
        fb_plot(step_to(x1, x2, k), step_to(y1, y2, (mdy * k) / mdx), on);
    end else begin
      for (int k = 0; k < mdy; k++)
        fb_plot(step_to(x1, x2, (mdx * k) / mdy), step_to(y1, y2, k), on);
    end
    fb_plot(x2, y2, on);
  endfunction

  function automatic fb_result_t fb_apply(draw_req_t r);
    fb_result_t res;
    res.data = '0;
    res.rd   = 1'b0;
    case (r.kind)
      REQ_PIXEL: fb_plot(int'(r.xs), int'(r.ys), r.on);
      REQ_LINE:  fb_line(int'(r.xs), int'(r.ys), int'(r.xe), int'(r.ye), r.on);
      REQ_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
      default: begin
        if (r.addr < FB_BYTES) res.data = shadow_fb[r.addr];
        res.rd = 1'b1;
      end
    endcase
    return res;
  endfunction

  function automatic draw_req_t mk_req(logic [1:0] kind, int xs, int ys, int xe, int ye,
                                       int on, int addr);
    draw_req_t r;
    r.kind = kind;
    r.xs   = COORD_W'(xs);
    r.ys   = COORD_W'(ys);
    r.xe   = COORD_W'(xe);
    r.ye   = COORD_W'(ye);
    r.on   = (on != 0);
    r.addr = ADDR_IN_W'(addr);
    return r;
  endfunction

  // mostly on-screen, sometimes anywhere in the 7-bit range
  function automatic int rand_coord(int hi);
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, hi) : $urandom_range(0, 127);
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t r;
    int pick;
    pick   = $urandom_range(0, 99);
    r.xs   = COORD_W'($urandom);
    r.ys   = COORD_W'($urandom);
    r.xe   = COORD_W'($urandom);
    r.ye   = COORD_W'($urandom);
    r.on   = ($urandom_range(0, 99) < 70);
    r.addr = ADDR_IN_W'($urandom);
    if (pick < 30) begin
      r.kind = REQ_PIXEL;
      r.xs   = COORD_W'(rand_coord(FB_W - 1));
      r.ys   = COORD_W'(rand_coord(FB_H - 1));
    end else if (pick < 55) begin
      r.kind = REQ_LINE;
      r.xs   = COORD_W'(rand_coord(FB_W - 1));
      r.ys   = COORD_W'(rand_coord(FB_H - 1));
      if ($urandom_range(0, 3) == 0) begin
        r.xe = COORD_W'(int'(r.xs) + $urandom_range(0, 6) - 3);
        r.ye = COORD_W'(int'(r.ys) + $urandom_range(0, 6) - 3);
      end else begin
        r.xe = COORD_W'(rand_coord(FB_W - 1));
        r.ye = COORD_W'(rand_coord(FB_H - 1));
      end
    end else if (pick < 58) begin
      r.kind = REQ_CLEAR;
    end else begin
      r.kind = REQ_READ;
      r.addr = ($urandom_range(0, 99) < 90) ? ADDR_IN_W'($urandom_range(0, FB_BYTES - 1))
                                            : ADDR_IN_W'($urandom_range(FB_BYTES, 1023));
    end
    return r;
  endfunction

  function automatic logic in_calm();
    return sent_cnt >= 250 && sent_cnt < 350;
  endfunction

  function automatic logic out_calm();
    return seen_cnt >= 250 && seen_cnt < 350;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(fb_apply(on_bus));
        kind_cnt[on_bus.kind]++;
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && (in_calm() || $urandom_range(0, 99) >= 31)) begin
          on_bus = pending_reqs.pop_front();
          in_req_type   <= on_bus.kind;
          in_x_start    <= on_bus.xs;
          in_y_start    <= on_bus.ys;
          in_x_end      <= on_bus.xe;
          in_y_end      <= on_bus.ye;
          in_set_pixels <= on_bus.on;
          in_read_addr  <= on_bus.addr;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_cnt++;
        if (due_results.size() == 0) begin
          $error("unexpected transfer: read_data %0h was_read %0b", out_read_data, out_was_read);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (out_read_data !== want.data) begin
            $error("read_data mismatch: expected %0h, got %0h", want.data, out_read_data);
            err_cnt++;
          end
          if (out_was_read !== want.rd) begin
            $error("was_read mismatch: expected %0b, got %0b", want.rd, out_was_read);
            err_cnt++;
          end
        end
      end
      out_stall <= !out_calm() && ($urandom_range(0, 99) < 31);
    end
  end

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    // directed: edges, off-frame drops, several directions, degenerate line, range reads
    pending_reqs.push_back(mk_req(REQ_READ, 127, 127, 127, 127, 1, 0));
    pending_reqs.push_back(mk_req(REQ_PIXEL, 0, 0, 5, 5, 1, 1023));
    pending_reqs.push_back(mk_req(REQ_PIXEL, FB_W - 1, FB_H - 1, 0, 0, 1, 0));
    pending_reqs.push_back(mk_req(REQ_PIXEL, 127, 127, 127, 127, 1, 1023));
    pending_reqs.push_back(mk_req(REQ_PIXEL, FB_W, FB_H - 1, 0, 0, 1, 0));
    pending_reqs.push_back(mk_req(REQ_PIXEL, FB_W - 1, FB_H, 0, 0, 1, 0));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, FB_BYTES - 1));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, FB_BYTES));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 1023));
    pending_reqs.push_back(mk_req(REQ_LINE, 0, 0, FB_W - 1, FB_H - 1, 1, 0));
    pending_reqs.push_back(mk_req(REQ_LINE, 10, 60, 3, 0, 1, 0));
    pending_reqs.push_back(mk_req(REQ_LINE, 90, 50, 127, 127, 1, 0));
    pending_reqs.push_back(mk_req(REQ_LINE, 50, 30, 50, 30, 1, 0));
    pending_reqs.push_back(mk_req(REQ_LINE, 100, 5, 2, 9, 1, 0));
    pending_reqs.push_back(mk_req(REQ_LINE, 20, 0, 20, 63, 1, 0));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 3 * FB_W + 50));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 20));
    pending_reqs.push_back(mk_req(REQ_LINE, FB_W - 1, FB_H - 1, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_PIXEL, 20, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 20));
    pending_reqs.push_back(mk_req(REQ_CLEAR, 127, 127, 127, 127, 1, 1023));
    pending_reqs.push_back(mk_req(REQ_READ, 0, 0, 0, 0, 0, 3 * FB_W + 50));
    repeat (RAND_REQS) pending_reqs.push_back(rand_req());
    total_reqs = pending_reqs.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt < total_reqs || due_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d pixel, %0d line, %0d clear and %0d read requests",
             kind_cnt[REQ_PIXEL], kind_cnt[REQ_LINE], kind_cnt[REQ_CLEAR], kind_cnt[REQ_READ]);
    $display("%0d results checked, %0d errors", seen_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mfld_pkg.sv
hdl/mfld_line_step.sv
hdl/mfld_frame_mem.sv
hdl/mono_framebuffer_line_drawer_unit.sv
tb/sv/tb_top.sv
